// ===== src/hrle_pkg.sv =====
// Shared types, constants and the keycode-to-ASCII mapping for the HID report line editor.
`default_nettype none

package hrle_pkg;

  // Line geometry: the line holds at most LINE_BYTES-1 characters
  localparam int LINE_BYTES = 64;
  localparam int POS_W      = 6;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       octet_t;
  typedef logic [2:0]       kind_t;

  localparam pos_t MAX_LEN = POS_W'(LINE_BYTES - 1);

  // Result kinds
  localparam kind_t KIND_IGNORED   = 3'd0;
  localparam kind_t KIND_INSERTED  = 3'd1;
  localparam kind_t KIND_FULL      = 3'd2;
  localparam kind_t KIND_DELETED   = 3'd3;
  localparam kind_t KIND_NO_DELETE = 3'd4;
  localparam kind_t KIND_MOVED     = 3'd5;
  localparam kind_t KIND_SENT      = 3'd6;
  localparam kind_t KIND_QUIT      = 3'd7;

  // Keycodes and modifier mask
  localparam octet_t SHIFT_MASK = 8'h22;
  localparam octet_t KEY_ENTER  = 8'h28;
  localparam octet_t KEY_ESCAPE = 8'h29;
  localparam octet_t KEY_BKSP   = 8'h2a;
  localparam octet_t KEY_RIGHT  = 8'h4f;
  localparam octet_t KEY_LEFT   = 8'h50;

  // Character tables
  localparam octet_t DIGIT_PLAIN [10] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                                          8'h36, 8'h37, 8'h38, 8'h39, 8'h30};
  localparam octet_t DIGIT_SHIFT [10] = '{8'h21, 8'h40, 8'h23, 8'h24, 8'h25,
                                          8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29};
  localparam octet_t SYMA_PLAIN [6] = '{8'h20, 8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h5c};
  localparam octet_t SYMA_SHIFT [6] = '{8'h20, 8'h5f, 8'h2b, 8'h7b, 8'h7d, 8'h7c};
  localparam octet_t SYMB_PLAIN [6] = '{8'h3b, 8'h27, 8'h60, 8'h2c, 8'h2e, 8'h2f};
  localparam octet_t SYMB_SHIFT [6] = '{8'h3a, 8'h22, 8'h7e, 8'h3c, 8'h3e, 8'h3f};

  // What a line cell does in one step
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    pos_t     pos;
    octet_t   ch;
  } cell_ctrl_t;

  // Map a keycode to its printable character, zero when not printable
  function automatic octet_t map_key(octet_t key, logic shift);
    octet_t     res;
    logic [3:0] di;
    logic [2:0] ai;
    logic [2:0] bi;
    res = 8'h00;
    di  = 4'(key - 8'h1e);
    ai  = 3'(key - 8'h2c);
    bi  = 3'(key - 8'h33);
    if (key >= 8'h04 && key <= 8'h1d) begin
      res = (shift ? 8'h41 : 8'h61) + (key - 8'h04);
    end else if (key >= 8'h1e && key <= 8'h27) begin
      res = shift ? DIGIT_SHIFT[di] : DIGIT_PLAIN[di];
    end else if (key >= 8'h2c && key <= 8'h31) begin
      res = shift ? SYMA_SHIFT[ai] : SYMA_PLAIN[ai];
    end else if (key >= 8'h33 && key <= 8'h38) begin
      res = shift ? SYMB_SHIFT[bi] : SYMB_PLAIN[bi];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/hrle_cell.sv =====
// One character cell of the line: holds a byte and trades it with its neighbors.
`default_nettype none

module hrle_cell (
  input  wire                 clk,
  input  hrle_pkg::pos_t      index,
  input  hrle_pkg::cell_ctrl_t ctrl,
  input  hrle_pkg::octet_t    left_data,
  input  hrle_pkg::octet_t    right_data,
  output hrle_pkg::octet_t    data
);

  // Insert opens a gap at pos, delete closes the gap below pos+1, shift drains to cell 0
  always_ff @(posedge clk) begin
    case (ctrl.op)
      hrle_pkg::CELL_INSERT: begin
        if (index == ctrl.pos) begin
          data <= ctrl.ch;
        end else if (index > ctrl.pos) begin
          data <= left_data;
        end
      end
      hrle_pkg::CELL_DELETE: begin
        if (index >= ctrl.pos) begin
          data <= right_data;
        end
      end
      hrle_pkg::CELL_SHIFT: begin
        data <= right_data;
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/hid_report_line_editor_top.sv =====
// Top level of the HID report line editor: report decode, edit control and the cell row.
// Usage:
//   Input channel s_axis_*: one word per boot-keyboard report (modifier byte and six
//   keycodes). Output channel m_axis_*: result words; m_axis_tlast marks the last
//   result caused by a report.
//   A report is taken when the block is idle; it is decoded once the output register is
//   free, and its single result is loaded into the output register in that decode step.
//   Enter on a non-empty line streams instead: the accept, the decode step, then one byte
//   per cycle from the head cell of the row while the receiver keeps up. Every edit
//   (insert, delete) is one parallel step of the cell row.
//   The rate is set by the decode step and by the one-byte-per-cycle drain of the row.
//   The output register lets a new report be taken while the last result still waits.
//   If the receiver stalls, decode and streaming wait for the output register to free.
//   Reset (rst, synchronous) empties the line, clears the previous keys and the halt
//   flag, and drops any pending output word. Escape halts the block until reset; while
//   halted every report answers with a quit result.
`default_nettype none

module hid_report_line_editor_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // modifier_bits, key_slot0 .. key_slot5, from the lowest bit up
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // event_kind[2:0], char_out[10:3], cursor_now[16:11], length_now[22:17], zero pad
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND
  } state_t;

  localparam hrle_pkg::pos_t POS_ONE = hrle_pkg::POS_W'(1);

  state_t                state;
  hrle_pkg::octet_t      rep_mod;
  hrle_pkg::octet_t      rep_keys [6];
  hrle_pkg::octet_t      prev_keys [6];
  hrle_pkg::pos_t        cursor;
  hrle_pkg::pos_t        length;
  hrle_pkg::pos_t        count;
  logic                  halted;

  hrle_pkg::kind_t       out_kind;
  hrle_pkg::octet_t      out_ch;
  hrle_pkg::pos_t        out_cursor;
  hrle_pkg::pos_t        out_length;

  logic                  out_free;
  logic                  out_load;
  logic [5:0]            seen;
  hrle_pkg::octet_t      new_key;
  hrle_pkg::octet_t      key_ch;
  logic                  shift;

  hrle_pkg::kind_t       res_kind;
  hrle_pkg::octet_t      res_ch;
  hrle_pkg::pos_t        cursor_next;
  hrle_pkg::pos_t        length_next;
  logic                  halt_set;
  logic                  go_send;
  hrle_pkg::cell_ctrl_t  dec_ctrl;
  hrle_pkg::cell_ctrl_t  cell_ctrl;

  hrle_pkg::octet_t      cell_data [hrle_pkg::LINE_BYTES];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && ((state == ST_DECODE && !go_send) || state == ST_SEND);
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {1'b0, out_length, out_cursor, out_ch, out_kind};

  // Find the first keycode absent from the previous report
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      seen[i] = 1'b0;
      for (int j = 0; j < 6; j++) begin
        if (rep_keys[i] == prev_keys[j]) begin
          seen[i] = 1'b1;
        end
      end
    end
    new_key = 8'h00;
    for (int i = 5; i >= 0; i--) begin
      if (!seen[i]) begin
        new_key = rep_keys[i];
      end
    end
  end

  assign shift  = |(rep_mod & hrle_pkg::SHIFT_MASK);
  assign key_ch = hrle_pkg::map_key(new_key, shift);

  // Decide the edit for the decoded key
  always_comb begin
    res_kind    = hrle_pkg::KIND_IGNORED;
    res_ch      = 8'h00;
    cursor_next = cursor;
    length_next = length;
    halt_set    = 1'b0;
    go_send     = 1'b0;
    dec_ctrl    = '{op: hrle_pkg::CELL_HOLD, pos: cursor, ch: key_ch};
    if (halted) begin
      res_kind = hrle_pkg::KIND_QUIT;
    end else if (new_key == hrle_pkg::KEY_ESCAPE) begin
      res_kind = hrle_pkg::KIND_QUIT;
      halt_set = 1'b1;
    end else if (key_ch != 8'h00) begin
      if (length >= hrle_pkg::MAX_LEN) begin
        res_kind = hrle_pkg::KIND_FULL;
      end else begin
        res_kind    = hrle_pkg::KIND_INSERTED;
        res_ch      = key_ch;
        cursor_next = cursor + 1'b1;
        length_next = length + 1'b1;
        dec_ctrl.op = hrle_pkg::CELL_INSERT;
      end
    end else if (new_key == hrle_pkg::KEY_BKSP) begin
      if (cursor == '0) begin
        res_kind = hrle_pkg::KIND_NO_DELETE;
      end else begin
        res_kind     = hrle_pkg::KIND_DELETED;
        cursor_next  = cursor - 1'b1;
        length_next  = length - 1'b1;
        dec_ctrl.op  = hrle_pkg::CELL_DELETE;
        dec_ctrl.pos = cursor - 1'b1;
      end
    end else if (new_key == hrle_pkg::KEY_RIGHT) begin
      if (cursor < length) begin
        res_kind    = hrle_pkg::KIND_MOVED;
        cursor_next = cursor + 1'b1;
      end
    end else if (new_key == hrle_pkg::KEY_LEFT) begin
      if (cursor != '0) begin
        res_kind    = hrle_pkg::KIND_MOVED;
        cursor_next = cursor - 1'b1;
      end
    end else if (new_key == hrle_pkg::KEY_ENTER && length != '0) begin
      go_send     = 1'b1;
      cursor_next = '0;
      length_next = '0;
    end
  end

  // Drive the cell row only on cycles that commit a step
  always_comb begin
    cell_ctrl = '{op: hrle_pkg::CELL_HOLD, pos: cursor, ch: key_ch};
    if (state == ST_DECODE && out_free) begin
      cell_ctrl = dec_ctrl;
    end else if (state == ST_SEND && out_free) begin
      cell_ctrl.op = hrle_pkg::CELL_SHIFT;
    end
  end

  // Row of line cells, cell 0 at the head of the line
  for (genvar g = 0; g < hrle_pkg::LINE_BYTES; g++) begin : g_cell
    hrle_pkg::octet_t left_in;
    hrle_pkg::octet_t right_in;
    if (g == 0) begin : g_head
      assign left_in = 8'h00;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == hrle_pkg::LINE_BYTES - 1) begin : g_tail
      assign right_in = 8'h00;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    hrle_cell u_cell (
      .clk        (clk),
      .index      (hrle_pkg::POS_W'(g)),
      .ctrl       (cell_ctrl),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g])
    );
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      halted        <= 1'b0;
      cursor        <= '0;
      length        <= '0;
      count         <= '0;
      for (int i = 0; i < 6; i++) begin
        prev_keys[i] <= 8'h00;
      end
    end else begin
      // Load a new word, or free the register once the current one is taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            rep_mod <= s_axis_tdata[7:0];
            for (int i = 0; i < 6; i++) begin
              rep_keys[i] <= s_axis_tdata[8*i+8 +: 8];
            end
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (out_free) begin
            cursor <= cursor_next;
            length <= length_next;
            if (halt_set) begin
              halted <= 1'b1;
            end
            if (!halted && !halt_set) begin
              prev_keys <= rep_keys;
            end
            if (go_send) begin
              count <= length;
              state <= ST_SEND;
            end else begin
              m_axis_tlast  <= 1'b1;
              out_kind      <= res_kind;
              out_ch        <= res_ch;
              out_cursor    <= cursor_next;
              out_length    <= length_next;
              state         <= ST_IDLE;
            end
          end
        end
        ST_SEND: begin
          if (out_free) begin
            m_axis_tlast  <= (count == POS_ONE);
            out_kind      <= hrle_pkg::KIND_SENT;
            out_ch        <= cell_data[0];
            out_cursor    <= '0;
            out_length    <= '0;
            count         <= count - 1'b1;
            if (count == POS_ONE) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Cursor never passes the end of the line
  assert property (@(posedge clk) disable iff (rst) cursor <= length)
    else $error("cursor beyond line length");

  // Line never exceeds its capacity
  assert property (@(posedge clk) disable iff (rst) length <= hrle_pkg::MAX_LEN)
    else $error("line length beyond capacity");

  // While streaming, the line has already been cleared and bytes remain to send
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> (length == '0 && cursor == '0 && count != '0))
    else $error("send state with live line or empty count");

  // Halt sticks until reset
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag dropped");

  // A streamed word always carries the line-byte kind
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && out_free) |=> (m_axis_tvalid && out_kind == hrle_pkg::KIND_SENT))
    else $error("streamed word lost or wrong kind");

endmodule

`default_nettype wire

// ===== tb/tb_hid_report_line_editor_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the HID report line editor: keyboard report stream against a predictor.
module tb_hid_report_line_editor_top;
  import hrle_pkg::*;

  // One boot-keyboard report; drain makes the sender wait until every result is back
  typedef struct packed {
    logic            drain;
    logic [5:0][7:0] keys;
    octet_t          mods;
  } report_t;

  // One result word as the editor should produce it
  typedef struct packed {
    kind_t  kind;
    octet_t ch;
    pos_t   cur;
    pos_t   len;
    logic   last;
  } edit_result_t;

  // Keycode ranges of the printable part of the keyboard
  localparam octet_t KEY_NONE   = 8'h00;
  localparam octet_t KEY_A      = 8'h04;
  localparam octet_t KEY_Z      = 8'h1d;
  localparam octet_t KEY_1      = 8'h1e;
  localparam octet_t KEY_0      = 8'h27;
  localparam octet_t KEY_SPACE  = 8'h2c;
  localparam octet_t KEY_BSLASH = 8'h31;
  localparam octet_t KEY_NONUS  = 8'h32;
  localparam octet_t KEY_SEMI   = 8'h33;
  localparam octet_t KEY_SLASH  = 8'h38;
  localparam octet_t KEY_MAX    = 8'hff;

  // Character rows, leftmost character in the top byte
  localparam logic [79:0] NUM_ROW    = "1234567890";
  localparam logic [79:0] NUM_ROW_SH = "!@#$%^&*()";
  localparam logic [47:0] SYM_A      = 48'h20_2d_3d_5b_5d_5c;  // space - = [ ] backslash
  localparam logic [47:0] SYM_A_SH   = 48'h20_5f_2b_7b_7d_7c;  // space _ + { } |
  localparam logic [47:0] SYM_B      = 48'h3b_27_60_2c_2e_2f;  // ; ' backtick , . /
  localparam logic [47:0] SYM_B_SH   = 48'h3a_22_7e_3c_3e_3f;  // : dquote ~ < > ?

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Editor state as the predictor sees it
  octet_t          line_buf [LINE_BYTES];
  int              line_len  = 0;
  int              caret     = 0;
  bit              stopped   = 1'b0;
  logic [5:0][7:0] held_keys = '0;

  edit_result_t    awaited [$];
  report_t         report_queue [$];
  report_t         in_flight;
  logic [5:0][7:0] last_sent = '0;

  int results_due  = 0;
  int results_seen = 0;
  int errors       = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int send_calm    = 0;
  int recv_calm    = 0;

  hid_report_line_editor_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Printable character of a keycode, zero when the key prints nothing
  function automatic octet_t ascii_of(octet_t key, logic shifted);
    int idx;
    idx = 0;
    if (key >= KEY_A && key <= KEY_Z) begin
      return (shifted ? "A" : "a") + (key - KEY_A);
    end else if (key >= KEY_1 && key <= KEY_0) begin
      idx = key - KEY_1;
      return shifted ? NUM_ROW_SH[8*(9-idx) +: 8] : NUM_ROW[8*(9-idx) +: 8];
    end else if (key >= KEY_SPACE && key <= KEY_BSLASH) begin
      idx = key - KEY_SPACE;
      return shifted ? SYM_A_SH[8*(5-idx) +: 8] : SYM_A[8*(5-idx) +: 8];
    end else if (key >= KEY_SEMI && key <= KEY_SLASH) begin
      idx = key - KEY_SEMI;
      return shifted ? SYM_B_SH[8*(5-idx) +: 8] : SYM_B[8*(5-idx) +: 8];
    end
    return 8'h00;
  endfunction

  // Record one expected result word with the current cursor and length
  function automatic void note_result(kind_t kind, octet_t ch, logic last);
    edit_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.cur  = pos_t'(caret);
    r.len  = pos_t'(line_len);
    r.last = last;
    awaited.push_back(r);
    results_due++;
  endfunction

  // Apply one accepted report to the line and queue the words it should cause
  task automatic edit_line(input report_t r);
    octet_t key;
    octet_t ch;
    logic   shifted;
    logic   seen;
    logic   found;
    int     sent_len;
    key   = KEY_NONE;
    found = 1'b0;
    if (stopped) begin
      note_result(KIND_QUIT, 8'h00, 1'b1);
      return;
    end
    shifted = (r.mods & SHIFT_MASK) != 8'h00;
    // first slot whose keycode was not held in the previous report
    for (int i = 0; i < 6; i++) begin
      seen = 1'b0;
      for (int j = 0; j < 6; j++) begin
        if (r.keys[i] == held_keys[j]) seen = 1'b1;
      end
      if (!seen && !found) begin
        key   = r.keys[i];
        found = 1'b1;
      end
    end
    if (key == KEY_ESCAPE) begin
      stopped = 1'b1;
      note_result(KIND_QUIT, 8'h00, 1'b1);
      return;
    end
    ch = ascii_of(key, shifted);
    if (ch != 8'h00) begin
      if (line_len + 1 >= LINE_BYTES) begin
        note_result(KIND_FULL, 8'h00, 1'b1);
      end else begin
        for (int k = line_len; k > caret; k--) line_buf[k] = line_buf[k-1];
        line_buf[caret] = ch;
        caret++;
        line_len++;
        note_result(KIND_INSERTED, ch, 1'b1);
      end
    end else if (key == KEY_BKSP) begin
      if (caret == 0) begin
        note_result(KIND_NO_DELETE, 8'h00, 1'b1);
      end else begin
        for (int k = caret - 1; k < line_len - 1; k++) line_buf[k] = line_buf[k+1];
        caret--;
        line_len--;
        note_result(KIND_DELETED, 8'h00, 1'b1);
      end
    end else if (key == KEY_RIGHT) begin
      if (caret < line_len) begin
        caret++;
        note_result(KIND_MOVED, 8'h00, 1'b1);
      end else begin
        note_result(KIND_IGNORED, 8'h00, 1'b1);
      end
    end else if (key == KEY_LEFT) begin
      if (caret > 0) begin
        caret--;
        note_result(KIND_MOVED, 8'h00, 1'b1);
      end else begin
        note_result(KIND_IGNORED, 8'h00, 1'b1);
      end
    end else if (key == KEY_ENTER && line_len > 0) begin
      sent_len = line_len;
      line_len = 0;
      caret    = 0;
      for (int i = 0; i < sent_len; i++) begin
        note_result(KIND_SENT, line_buf[i], i == sent_len - 1);
      end
    end else begin
      note_result(KIND_IGNORED, 8'h00, 1'b1);
    end
    held_keys = r.keys;
  endtask

  // Compare one received word with the oldest expectation
  task automatic check_result(logic [23:0] word, logic last);
    edit_result_t want;
    if (awaited.size() == 0) begin
      $error("result word %h arrived with nothing awaited", word);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (word[2:0] !== want.kind) begin
      $error("event_kind expected %0d actual %0d", want.kind, word[2:0]);
      errors++;
    end
    if (word[10:3] !== want.ch) begin
      $error("char_out expected %h actual %h", want.ch, word[10:3]);
      errors++;
    end
    if (word[16:11] !== want.cur) begin
      $error("cursor_now expected %0d actual %0d", want.cur, word[16:11]);
      errors++;
    end
    if (word[22:17] !== want.len) begin
      $error("length_now expected %0d actual %0d", want.len, word[22:17]);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_of_run expected %0d actual %0d", want.last, last);
      errors++;
    end
  endtask

  // Pause length: mostly none or short, a few long, and now and then a calm stretch
  function automatic int draw_pause(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_report(octet_t mods, logic [5:0][7:0] keys, logic drain);
    report_t r;
    r.drain = drain;
    r.keys  = keys;
    r.mods  = mods;
    report_queue.push_back(r);
    last_sent = keys;
  endfunction

  // Report in which key is the first new one: held keys before it, noise after it
  function automatic void press_key(octet_t key, octet_t mods, logic drain);
    logic [5:0][7:0] keys;
    bit              clash;
    int              p;
    clash = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (last_sent[i] == key) clash = 1'b1;
    end
    // release everything first when the key is still held
    if (clash) queue_report(octet_t'($urandom_range(0, 255)), '0, drain);
    p = $urandom_range(0, 5);
    for (int i = 0; i < 6; i++) begin
      if (i < p) keys[i] = last_sent[$urandom_range(0, 5)];
      else if (i == p) keys[i] = key;
      else keys[i] = octet_t'($urandom);
    end
    queue_report(mods, keys, drain);
  endfunction

  function automatic void noise_report(logic drain);
    logic [5:0][7:0] keys;
    for (int i = 0; i < 6; i++) begin
      keys[i] = octet_t'($urandom);
      if (keys[i] == KEY_ESCAPE) keys[i] = KEY_NONE;
    end
    queue_report(octet_t'($urandom), keys, drain);
  endfunction

  function automatic octet_t pick_printable();
    octet_t k;
    k = octet_t'($urandom_range(KEY_A, KEY_SLASH));
    while (ascii_of(k, 1'b0) == 8'h00) k = octet_t'($urandom_range(KEY_A, KEY_SLASH));
    return k;
  endfunction

  function automatic octet_t pick_edit_key();
    octet_t k;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 52) begin
      k = pick_printable();
    end else if (roll < 64) begin
      k = KEY_BKSP;
    end else if (roll < 74) begin
      k = KEY_LEFT;
    end else if (roll < 82) begin
      k = KEY_RIGHT;
    end else if (roll < 88) begin
      k = KEY_ENTER;
    end else begin
      k = octet_t'($urandom_range(1, 255));
      while (ascii_of(k, 1'b0) != 8'h00 || k == KEY_ENTER || k == KEY_ESCAPE ||
             k == KEY_BKSP || k == KEY_LEFT || k == KEY_RIGHT) begin
        k = octet_t'($urandom_range(1, 255));
      end
    end
    return k;
  endfunction

  // Sender: present queued reports, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        edit_line(in_flight);
        gap_left = draw_pause(send_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left == 0 && report_queue.size() != 0 &&
            !(report_queue[0].drain && results_seen != results_due)) begin
          in_flight = report_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.keys, in_flight.mods};
        end else begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every accepted word, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tlast);
        results_seen <= results_seen + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = draw_pause(recv_calm);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int  roll;
    bit  filled;
    filled = 1'b0;

    // directed: empty-line corners, ends of every character row, edits mid-line
    queue_report(8'h00, '0, 1'b0);
    press_key(KEY_ENTER, 8'h00, 1'b0);
    press_key(KEY_BKSP, 8'h00, 1'b0);
    press_key(KEY_LEFT, 8'h00, 1'b0);
    press_key(KEY_RIGHT, 8'h00, 1'b0);
    press_key(KEY_A, 8'h00, 1'b0);
    press_key(KEY_Z, 8'h02, 1'b0);
    press_key(KEY_1, 8'h20, 1'b0);
    press_key(KEY_0, 8'h00, 1'b0);
    press_key(KEY_SPACE, 8'hff, 1'b0);
    press_key(KEY_BSLASH, 8'hdd, 1'b0);
    press_key(KEY_SEMI, 8'h22, 1'b0);
    press_key(KEY_SLASH, 8'h20, 1'b0);
    press_key(KEY_MAX, 8'h00, 1'b0);
    press_key(KEY_NONUS, 8'h00, 1'b0);
    press_key(KEY_LEFT, 8'h00, 1'b0);
    press_key(KEY_LEFT, 8'h00, 1'b0);
    press_key(KEY_Z, 8'h00, 1'b0);
    press_key(KEY_RIGHT, 8'h00, 1'b0);
    press_key(KEY_BKSP, 8'h00, 1'b0);
    queue_report(8'hff, {6{KEY_MAX}}, 1'b0);
    press_key(KEY_ENTER, 8'h00, 1'b0);

    // random typing, with one burst that runs the line full
    press_key(pick_edit_key(), octet_t'($urandom), 1'b1);
    while (report_queue.size() < 300) begin
      if (!filled && report_queue.size() >= 150) begin
        filled = 1'b1;
        for (int i = 0; i < 68; i++) press_key(pick_printable(), octet_t'($urandom), i == 0);
        press_key(KEY_LEFT, octet_t'($urandom), 1'b0);
        press_key(KEY_LEFT, octet_t'($urandom), 1'b0);
        press_key(KEY_BKSP, octet_t'($urandom), 1'b0);
        press_key(pick_printable(), octet_t'($urandom), 1'b0);
        press_key(pick_printable(), octet_t'($urandom), 1'b0);
        press_key(KEY_ENTER, octet_t'($urandom), 1'b0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 7) noise_report(roll == 0);
      else if (roll < 12) queue_report(octet_t'($urandom), last_sent, 1'b0);
      else press_key(pick_edit_key(), octet_t'($urandom), roll == 50);
    end

    // halt, then reports that must all answer quit
    press_key(KEY_ESCAPE, octet_t'($urandom), 1'b1);
    repeat (4) noise_report(1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (report_queue.size() != 0 || s_axis_tvalid);
    while (results_seen < results_due) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0 && results_seen == results_due) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #25ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
